/* rtl/core/idt_pkg.sv */
// Shared types and sizing constants for the ID occupancy tracker.
// Every module of the tracker imports this package; it depends on nothing else.
`timescale 1ns / 1ps

package idt_pkg;

   localparam int KEY_SPACE = 1024;
   localparam int KEY_W     = $clog2(KEY_SPACE);
   localparam int FP_W      = KEY_W + 1;
   localparam int WORD_W    = 32;
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int ROW_COUNT = KEY_SPACE / WORD_W;
   localparam int ROW_W     = $clog2(ROW_COUNT);

   // Request action codes.
   localparam logic ACT_ADD    = 1'b0;
   localparam logic ACT_DELETE = 1'b1;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic {
      SCAN_FWD_FREE,
      SCAN_REV_USED
   } scan_dir_type;

   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] addr;
      word_type         data;
   } ram_write_type;

endpackage

/* rtl/core/idt_bitmap_ram.sv */
// Occupancy bitmap storage: one row of WORD_W bits per address, registered read.
// Uses idt_pkg; per-row valid bits make rows read as empty until first written.
`timescale 1ns / 1ps

module idt_bitmap_ram
   import idt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ram_write_type    wr,
   input  logic [ROW_W-1:0] rd_addr,
   output word_type         rd_word
);

   word_type               mem_ff [ROW_COUNT];
   logic [ROW_COUNT-1:0]   row_valid_ff;
   word_type               rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // A row never written since reset holds no occupied IDs.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr.en) begin
            row_valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_word = rd_valid_ff ? rd_data_ff : '0;

endmodule

/* rtl/core/idt_scan_unit.sv */
// Shared priority encoder for the tracker: finds the lowest free bit at or above
// a bound, or the highest used bit below a bound, in one bitmap row. Uses idt_pkg.
`timescale 1ns / 1ps

module idt_scan_unit
   import idt_pkg::*;
(
   input  word_type         word,
   input  scan_dir_type     dir,
   input  logic [BIT_W:0]   bound,
   output logic             hit,
   output logic [BIT_W-1:0] idx
);

   word_type upper_mask;
   word_type cand;

   always_comb begin
      upper_mask = {WORD_W{1'b1}} << bound;
      if (dir == SCAN_FWD_FREE) begin
         cand = ~word & upper_mask;
      end else begin
         cand = word & ~upper_mask;
      end
      hit = |cand;
      idx = '0;
      if (dir == SCAN_FWD_FREE) begin
         // Walk downward so the lowest candidate is the last one taken.
         for (int i = WORD_W - 1; i >= 0; i--) begin
            if (cand[i]) begin
               idx = BIT_W'(i);
            end
         end
      end else begin
         for (int i = 0; i < WORD_W; i++) begin
            if (cand[i]) begin
               idx = BIT_W'(i);
            end
         end
      end
   end

endmodule

/* rtl/core/id_occupancy_tracker.sv */
// Top level of the ID occupancy tracker: command sequencer, pointer registers.
// Uses idt_pkg, idt_bitmap_ram and idt_scan_unit.
//
//   Channel   Ports                                         Handshake
//   request   req_action, req_key                           start & !busy
//   response  rsp_found, rsp_first_free, rsp_highest_used   rsp_strobe, one cycle
//
// A transaction updates the key's bitmap row in ST_UPDATE and registers rsp_strobe
// there if no scan leaves that row; else the free-ID or highest-ID scan visits up
// to ROW_COUNT - 1 further rows (31 for 1024 IDs) through the single bitmap read
// port. busy is high throughout; start may be raised again in the cycle of
// rsp_strobe. Reset is synchronous and leaves the tracker empty and idle at once.
// The receiver cannot stall responses.
`timescale 1ns / 1ps

module id_occupancy_tracker
   import idt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_action,
   input  logic [KEY_W-1:0] req_key,
   output logic             rsp_strobe,
   output logic             rsp_found,
   output logic [FP_W-1:0]  rsp_first_free,
   output logic [KEY_W-1:0] rsp_highest_used
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SCAN_UP,
      ST_SCAN_DOWN
   } state_type;

   state_type        state_ff, state_in;
   logic             act_ff, act_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [FP_W-1:0]  fp_ff, fp_in;
   logic [KEY_W-1:0] top_ff, top_in;
   logic             found_ff, found_in;
   logic             strobe_ff, strobe_in;
   logic [ROW_W-1:0] scan_row_ff, scan_row_in;

   ram_write_type    wr;
   logic [ROW_W-1:0] rd_addr;
   word_type         rd_word;

   scan_dir_type     scan_dir;
   word_type         scan_word;
   logic [BIT_W:0]   scan_bound;
   logic             scan_hit;
   logic [BIT_W-1:0] scan_idx;

   logic [ROW_W-1:0] key_row;
   logic [BIT_W-1:0] key_bit;
   logic             key_ok;
   logic             key_hit;
   word_type         bit_mask;
   word_type         upd_word;

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROW_COUNT - 1);

   idt_bitmap_ram u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_word (rd_word)
   );

   idt_scan_unit u_scan (
      .word  (scan_word),
      .dir   (scan_dir),
      .bound (scan_bound),
      .hit   (scan_hit),
      .idx   (scan_idx)
   );

   assign key_row  = key_ff[BIT_W +: ROW_W];
   assign key_bit  = key_ff[BIT_W-1:0];
   assign key_ok   = (key_ff != '0) && ({1'b0, key_ff} < FP_W'(KEY_SPACE));
   assign bit_mask = word_type'(1) << key_bit;
   assign key_hit  = key_ok && ((rd_word & bit_mask) != '0);
   assign upd_word = (act_ff == ACT_ADD) ? (rd_word | bit_mask) : (rd_word & ~bit_mask);

   // Scan unit operand selection: the first row sees the updated word, later
   // rows come straight from the bitmap.
   always_comb begin
      scan_word  = rd_word;
      scan_dir   = SCAN_FWD_FREE;
      scan_bound = '0;
      unique case (state_ff)
         ST_UPDATE: begin
            scan_word = upd_word;
            if (act_ff == ACT_ADD) begin
               scan_dir   = SCAN_FWD_FREE;
               scan_bound = {1'b0, key_bit} + (BIT_W + 1)'(1);
            end else begin
               scan_dir   = SCAN_REV_USED;
               scan_bound = {1'b0, key_bit};
            end
         end
         ST_SCAN_UP: begin
            scan_dir   = SCAN_FWD_FREE;
            scan_bound = '0;
         end
         ST_SCAN_DOWN: begin
            scan_dir   = SCAN_REV_USED;
            scan_bound = (BIT_W + 1)'(WORD_W);
         end
         default: begin
            scan_dir = SCAN_FWD_FREE;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      key_in      = key_ff;
      fp_in       = fp_ff;
      top_in      = top_ff;
      found_in    = found_ff;
      strobe_in   = 1'b0;
      scan_row_in = scan_row_ff;
      wr          = '0;
      rd_addr     = scan_row_ff;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = req_key[BIT_W +: ROW_W];
            if (start) begin
               act_in   = req_action;
               key_in   = req_key;
               state_in = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            found_in = key_hit;
            state_in = ST_IDLE;
            if (!key_ok) begin
               strobe_in = 1'b1;
            end else if (act_ff == ACT_ADD) begin
               wr.en   = 1'b1;
               wr.addr = key_row;
               wr.data = upd_word;
               if (key_ff > top_ff) begin
                  top_in = key_ff;
               end
               if ({1'b0, key_ff} == fp_ff) begin
                  if (scan_hit) begin
                     fp_in     = FP_W'({key_row, scan_idx});
                     strobe_in = 1'b1;
                  end else if (key_row == LAST_ROW) begin
                     fp_in     = FP_W'(KEY_SPACE);
                     strobe_in = 1'b1;
                  end else begin
                     rd_addr     = key_row + ROW_W'(1);
                     scan_row_in = key_row + ROW_W'(1);
                     state_in    = ST_SCAN_UP;
                  end
               end else begin
                  strobe_in = 1'b1;
               end
            end else if (key_hit) begin
               wr.en   = 1'b1;
               wr.addr = key_row;
               wr.data = upd_word;
               if ({1'b0, key_ff} < fp_ff) begin
                  fp_in = {1'b0, key_ff};
               end
               if (key_ff == top_ff) begin
                  if (scan_hit) begin
                     top_in    = KEY_W'({key_row, scan_idx});
                     strobe_in = 1'b1;
                  end else if (key_row == '0) begin
                     top_in    = '0;
                     strobe_in = 1'b1;
                  end else begin
                     rd_addr     = key_row - ROW_W'(1);
                     scan_row_in = key_row - ROW_W'(1);
                     state_in    = ST_SCAN_DOWN;
                  end
               end else begin
                  strobe_in = 1'b1;
               end
            end else begin
               strobe_in = 1'b1;
            end
         end

         ST_SCAN_UP: begin
            if (scan_hit) begin
               fp_in     = FP_W'({scan_row_ff, scan_idx});
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else if (scan_row_ff == LAST_ROW) begin
               fp_in     = FP_W'(KEY_SPACE);
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               rd_addr     = scan_row_ff + ROW_W'(1);
               scan_row_in = scan_row_ff + ROW_W'(1);
            end
         end

         ST_SCAN_DOWN: begin
            // ID 0 is never occupied, so an empty bottom row means no ID is in use.
            if (scan_hit) begin
               top_in    = KEY_W'({scan_row_ff, scan_idx});
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else if (scan_row_ff == '0) begin
               top_in    = '0;
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               rd_addr     = scan_row_ff - ROW_W'(1);
               scan_row_in = scan_row_ff - ROW_W'(1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fp_ff     <= FP_W'(1);
         top_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fp_ff     <= fp_in;
         top_ff    <= top_in;
         strobe_ff <= strobe_in;
      end
      act_ff      <= act_in;
      key_ff      <= key_in;
      found_ff    <= found_in;
      scan_row_ff <= scan_row_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_found        = found_ff;
   assign rsp_first_free   = fp_ff;
   assign rsp_highest_used = top_ff;

endmodule
